@@ rtl/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared item types, field widths and register codes of the resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int CADDR_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int HIST_W     = 6;
    localparam int OUT_CAP    = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_FRAC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INCREMENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_SCALE      = 3'd5;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    typedef struct packed {
        logic                       cmd;
        logic [CADDR_W-1:0]         coef_addr;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [SAMPLE_W-1:0] sample_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       last_of_run;
        logic                       clipped;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/bsr_coef_mem.sv @@
// ----------------------------------------------------------------------------
// bsr_coef_mem
// Coefficient memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_coef_mem #(
    parameter int COEF_WORDS = 8192,
    parameter int AW         = 14
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_we,
    input  wire logic [AW-1:0]                     i_waddr,
    input  wire logic signed [bsr_pkg::COEF_W-1:0] i_wdata,
    input  wire logic [AW-1:0]                     i_raddr,
    output logic signed [bsr_pkg::COEF_W-1:0]      o_rdata
);
    import bsr_pkg::*;

    localparam int CI_W = $clog2(COEF_WORDS);

    logic signed [COEF_W-1:0] mem [COEF_WORDS];
    logic signed [COEF_W-1:0] r_q;
    logic                     r_oob;

    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr < AW'(COEF_WORDS))) begin
            mem[i_waddr[CI_W-1:0]] <= i_wdata;
        end
        r_q   <= mem[i_raddr[CI_W-1:0]];
        r_oob <= (i_raddr >= AW'(COEF_WORDS));
    end

    // Reads beyond the memory return zero.
    assign o_rdata = r_oob ? '0 : r_q;

endmodule

`default_nettype wire

@@ rtl/bsinc_polyphase_resampler_top.sv @@
// ----------------------------------------------------------------------------
// bsinc_polyphase_resampler_top
// Streaming polyphase sinc resampler with coefficient memory and sample ring.
// ----------------------------------------------------------------------------
// Sequence: a push first checks the window, then each output reads four
// coefficient words per tap with scale tables (two without), then rounds and emits.
// Throughput: one item at a time; set by the single coefficient read port.
// Coefficient loads are written only while idle.
// Reset: synchronous active low; registers take their reset values, the
// history reads as zero through valid bits, coefficient memory is not cleared.
`default_nettype none

module bsinc_polyphase_resampler_top #(
    parameter int FRAC_BITS  = 16,
    parameter int PHASE_BITS = 5,
    parameter int MAX_TAPS   = 48,
    parameter int EDGE       = 24,
    parameter int COEF_WORDS = 8192
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire bsr_pkg::t_in_item                   i_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output bsr_pkg::t_out_item                       o_out,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bsr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [bsr_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bsr_pkg::*;

    localparam int DIFF_BITS = FRAC_BITS - PHASE_BITS;
    localparam int DW        = (DIFF_BITS > 0) ? DIFF_BITS : 1;
    localparam int TOP_TAPS  = (MAX_TAPS / 4) * 4;
    localparam int MIN_STEP  = (1 << FRAC_BITS) >> 6;
    localparam int CA_W      = $clog2(COEF_WORDS) + 1;
    localparam int AW        = (PHASE_BITS + 9 > CA_W) ? PHASE_BITS + 9 : CA_W;
    localparam int AWD       = 42;               // tap term before phase blend
    localparam int NW        = AWD + 1 + DIFF_BITS;
    localparam int FW        = NW - 8 - DIFF_BITS; // tap in Q.30
    localparam int ACW       = FW + SAMPLE_W + 7;
    localparam int HDEPTH    = 1 << HIST_W;

    localparam logic signed [NW-1:0]  HALF_N = NW'(1) << (7 + DIFF_BITS);
    localparam logic signed [ACW-1:0] HALF_A = ACW'(1) << 29;
    localparam logic signed [ACW-1:0] Y_MAX  = ACW'(8388607);
    localparam logic signed [ACW-1:0] Y_MIN  = -ACW'(8388608);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_RA, S_RB, S_RC, S_RD, S_RE,
        S_NUM, S_F30, S_MAC, S_ADV, S_EMIT
    } t_state;

    // Configuration registers.
    logic [15:0] r_init;
    logic [19:0] r_step;
    logic [5:0]  r_taps;
    logic [4:0]  r_edge;
    logic [16:0] r_scale;
    logic        r_use;

    // Stream state.
    t_state                   r_state;
    logic [FRAC_BITS-1:0]     r_phase;
    logic [31:0]              r_ws;
    logic [31:0]              r_seen;
    logic [6:0]               r_count;
    logic [6:0]               r_j;
    logic [AW-1:0]            r_fil;
    logic signed [AWD-1:0]    r_a;
    logic signed [AWD-1:0]    r_b;
    logic signed [NW-1:0]     r_num;
    logic signed [FW-1:0]     r_f30;
    logic signed [ACW-1:0]    r_acc;
    logic signed [SAMPLE_W-1:0] r_y;
    logic                     r_clip;

    // Sample ring; an entry without its valid bit reads as zero.
    logic signed [SAMPLE_W-1:0] hist [HDEPTH];
    logic [HDEPTH-1:0]          r_hvalid;
    logic signed [SAMPLE_W-1:0] r_hq;
    logic                       r_hv;

    logic      r_out_valid;
    t_out_item r_out;

    // Effective tap count: multiple of four, clamped.
    logic [6:0] eff_m;
    always_comb begin
        eff_m = {1'b0, r_taps[5:2], 2'b00};
        if (eff_m < 7'd4) eff_m = 7'd4;
        if (eff_m > 7'(TOP_TAPS)) eff_m = 7'(TOP_TAPS);
    end

    logic [16:0] sf;
    logic signed [17:0] sf_s;
    assign sf   = r_use ? ((r_scale > 17'd65536) ? 17'd65536 : r_scale) : 17'd0;
    assign sf_s = $signed({1'b0, sf});

    logic [19:0] step;
    assign step = (r_step < 20'(MIN_STEP)) ? 20'(MIN_STEP) : r_step;

    // A window is due once all of its samples have arrived.
    logic [31:0] c_d;
    logic        win_ok;
    assign c_d    = r_seen - r_ws;
    assign win_ok = !c_d[31] && (c_d >= 32'(eff_m));

    // Filter row base for the current phase.
    logic [PHASE_BITS-1:0] c_pi;
    logic [AW-1:0]         c_fil;
    logic [AW-1:0]         c_pcm;
    logic [AW-1:0]         c_m;
    logic [AW-1:0]         c_j;
    assign c_pi  = r_phase[FRAC_BITS-1 -: PHASE_BITS];
    assign c_m   = AW'(eff_m);
    assign c_fil = AW'({c_pi, 1'b0}) * c_m;
    assign c_pcm = c_m << (PHASE_BITS + 1);
    assign c_j   = AW'(r_j);

    logic signed [DW:0] pfi_s;
    assign pfi_s = (DIFF_BITS > 0) ? $signed({1'b0, r_phase[DW-1:0]}) : '0;

    // Coefficient read address follows the tap sequence.
    logic [AW-1:0] c_raddr;
    always_comb begin
        case (r_state)
            S_RA:    c_raddr = r_fil + c_j;
            S_RB:    c_raddr = r_fil + c_m + c_j;
            S_RC:    c_raddr = r_fil + c_pcm + c_j;
            S_RD:    c_raddr = r_fil + c_pcm + c_m + c_j;
            default: c_raddr = r_fil;
        endcase
    end

    // Registers are written only between items, and an item waits while a
    // register write is offered.
    logic in_acc;
    logic cfg_acc;
    logic coef_we;
    logic signed [COEF_W-1:0] cq;
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign coef_we     = in_acc && (i_in.cmd == CMD_LOAD);

    bsr_coef_mem #(
        .COEF_WORDS (COEF_WORDS),
        .AW         (AW)
    ) u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (AW'(i_in.coef_addr)),
        .i_wdata (i_in.coef_value),
        .i_raddr (c_raddr),
        .o_rdata (cq)
    );

    // Arithmetic between registers.
    logic signed [AWD-1:0] c_cs;
    logic signed [NW-1:0]  c_num;
    logic signed [NW-1:0]  c_sh;
    logic signed [SAMPLE_W-1:0] c_smp;
    logic signed [ACW-1:0] c_mac;
    logic signed [ACW-1:0] c_y;
    assign c_cs  = AWD'(cq) * AWD'(sf_s);
    assign c_num = (NW'(r_a) <<< DIFF_BITS) + NW'(r_b) * NW'(pfi_s);
    assign c_sh  = (r_num + HALF_N) >>> (8 + DIFF_BITS);
    assign c_smp = r_hv ? r_hq : '0;
    assign c_mac = ACW'(r_f30) * ACW'(c_smp);
    assign c_y   = (r_acc + HALF_A) >>> 30;

    logic [20:0] c_sum;
    assign c_sum = 21'(r_phase) + 21'(step);

    logic [HIST_W-1:0] c_hidx;
    assign c_hidx = r_ws[HIST_W-1:0] + r_j[HIST_W-1:0];

    logic out_free;
    logic cont;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cont     = (r_count < 7'(OUT_CAP)) && win_ok;

    // Restart values use the register as it is being written.
    logic [15:0] rs_init;
    logic [4:0]  rs_edge;
    logic [5:0]  rs_eff;
    assign rs_init = (i_cfg_index == CFG_INITIAL_FRAC) ? i_cfg_data[15:0] : r_init;
    assign rs_edge = (i_cfg_index == CFG_EDGE_OFFSET) ? i_cfg_data[4:0] : r_edge;
    assign rs_eff  = ({1'b0, rs_edge} > 6'(EDGE)) ? 6'(EDGE) : {1'b0, rs_edge};

    // Ring memory, written on push and read once per tap.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_in.cmd == CMD_PUSH)) begin
            hist[r_seen[HIST_W-1:0]] <= i_in.sample_in;
        end
        if (r_state == S_RA) begin
            r_hq <= hist[c_hidx];
            r_hv <= r_hvalid[c_hidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 16'd0;
            r_step      <= 20'd65536;
            r_taps      <= 6'd8;
            r_edge      <= 5'd4;
            r_scale     <= 17'd0;
            r_use       <= 1'b1;
            r_phase     <= '0;
            r_ws        <= 32'(EDGE) - ((EDGE < 4) ? 32'(EDGE) : 32'd4);
            r_seen      <= '0;
            r_count     <= '0;
            r_j         <= '0;
            r_hvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the emit state the output register is refilled instead.
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_in.cmd == CMD_PUSH)) begin
                        r_hvalid[r_seen[HIST_W-1:0]] <= 1'b1;
                        r_seen  <= r_seen + 32'd1;
                        r_count <= '0;
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (win_ok) begin
                        r_fil   <= c_fil;
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= S_RA;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RA: r_state <= S_RB;
                S_RB: begin
                    r_a     <= {{(AWD-40){cq[COEF_W-1]}}, cq, 16'd0};
                    r_state <= S_RC;
                end
                S_RC: begin
                    r_b     <= {{(AWD-40){cq[COEF_W-1]}}, cq, 16'd0};
                    r_state <= (sf != 17'd0) ? S_RD : S_NUM;
                end
                S_RD: begin
                    r_a     <= r_a + c_cs;
                    r_state <= S_RE;
                end
                S_RE: begin
                    r_b     <= r_b + c_cs;
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num   <= c_num;
                    r_state <= S_F30;
                end
                S_F30: begin
                    r_f30   <= c_sh[FW-1:0];
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    r_acc <= r_acc + c_mac;
                    r_j   <= r_j + 7'd1;
                    if (r_j + 7'd1 == eff_m) begin
                        r_state <= S_ADV;
                    end else begin
                        r_state <= S_RA;
                    end
                end
                S_ADV: begin
                    // Round to Q1.23, saturate, then advance the phase.
                    if (c_y > Y_MAX) begin
                        r_y    <= SAMPLE_W'(8388607);
                        r_clip <= 1'b1;
                    end else if (c_y < Y_MIN) begin
                        r_y    <= -SAMPLE_W'(8388608);
                        r_clip <= 1'b1;
                    end else begin
                        r_y    <= c_y[SAMPLE_W-1:0];
                        r_clip <= 1'b0;
                    end
                    r_phase <= c_sum[FRAC_BITS-1:0];
                    r_ws    <= r_ws + 32'(c_sum[20:FRAC_BITS]);
                    r_count <= r_count + 7'd1;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.sample_out  <= r_y;
                        r_out.clipped     <= r_clip;
                        r_out.last_of_run <= !cont;
                        if (cont) begin
                            r_fil   <= c_fil;
                            r_j     <= '0;
                            r_acc   <= '0;
                            r_state <= S_RA;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_INITIAL_FRAC:   r_init  <= i_cfg_data[15:0];
                    CFG_STEP_INCREMENT: r_step  <= i_cfg_data;
                    CFG_TAP_COUNT:      r_taps  <= i_cfg_data[5:0];
                    CFG_EDGE_OFFSET:    r_edge  <= i_cfg_data[4:0];
                    CFG_SCALE_FACTOR:   r_scale <= i_cfg_data[16:0];
                    CFG_USE_SCALE:      r_use   <= i_cfg_data[0];
                    default: ;
                endcase
                // Writing the start phase or the edge restarts the stream.
                if ((i_cfg_index == CFG_INITIAL_FRAC) || (i_cfg_index == CFG_EDGE_OFFSET)) begin
                    r_phase  <= FRAC_BITS'(rs_init);
                    r_ws     <= 32'(EDGE) - 32'(rs_eff);
                    r_seen   <= '0;
                    r_hvalid <= '0;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
